// ===== sv/mdg_pkg.sv =====
package mdg_pkg;

    localparam int MAX_CELLS      = 1024;
    localparam int MAX_NEIGHBOURS = 4;

    localparam int ADDR_W   = $clog2(MAX_CELLS);
    localparam int CNT_W    = $clog2(MAX_CELLS + 1);
    localparam int NB_IDX_W = $clog2(MAX_NEIGHBOURS);
    localparam int NB_CNT_W = $clog2(MAX_NEIGHBOURS + 1);

    localparam int VERT_W  = 32;
    localparam int NVERT   = 4;
    localparam int CELL_W  = VERT_W * NVERT;
    localparam int SHARE_W = 3;
    localparam int CFG_IDX_W = 2;

    // input kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_MANY = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_BAD_IDX  = 2'd3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TDIM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;

    // result of comparing one stored cell against the query cell
    typedef struct packed {
        logic               vld;
        logic [ADDR_W-1:0]  idx;
        logic [SHARE_W-1:0] shared;
    } t_match_res;

endpackage

// ===== sv/mdg_ram.sv =====
module mdg_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mdg_match.sv =====
module mdg_match (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  logic [mdg_pkg::ADDR_W-1:0]     i_idx,
    input  logic [mdg_pkg::CELL_W-1:0]     i_cell,
    input  logic [mdg_pkg::CELL_W-1:0]     i_qcell,
    input  logic [2:0]                     i_nv,
    output mdg_pkg::t_match_res            o_res
);
    import mdg_pkg::*;

    logic                           r_vld;
    logic [ADDR_W-1:0]              r_idx;
    logic [NVERT-1:0][NVERT-1:0]    r_eq;
    logic [NVERT-1:0][NVERT-1:0]    eq;
    logic [SHARE_W-1:0]             cnt;

    // stage 1: all pairwise vertex compares, masked to the first nv vertices
    always_comb begin
        for (int i = 0; i < NVERT; i++) begin
            for (int k = 0; k < NVERT; k++) begin
                eq[i][k] = (3'(i) < i_nv) && (3'(k) < i_nv) &&
                           (i_qcell[i*VERT_W +: VERT_W] == i_cell[k*VERT_W +: VERT_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_idx <= i_idx;
        r_eq  <= eq;
    end

    // stage 2: greedy pairing; equality classes make this the multiset count
    always_comb begin
        logic [NVERT-1:0] used;
        logic             hit;
        used = '0;
        cnt  = '0;
        for (int i = 0; i < NVERT; i++) begin
            hit = 1'b0;
            for (int k = 0; k < NVERT; k++) begin
                if (!hit && r_eq[i][k] && !used[k]) begin
                    used[k] = 1'b1;
                    hit     = 1'b1;
                end
            end
            if (hit) begin
                cnt = cnt + 3'd1;
            end
        end
    end

    assign o_res.vld    = r_vld;
    assign o_res.idx    = r_idx;
    assign o_res.shared = cnt;

endmodule

// ===== sv/mesh_dual_graph_neighbours.sv =====
// Facet-adjacency engine over a table of simplex cells held in one on-chip
// memory (MAX_CELLS entries of four 32-bit vertices). A load transfer appends
// a cell (ignored when the table is full), a clear transfer empties the
// table. A query transfer names a stored cell; the block reads it, then
// streams every stored cell through the single memory read port, one entry
// per cycle, into a two-stage vertex matcher. A cell sharing exactly tdim
// vertices with the query (tdim 0 acts as 1) is a facet neighbour and is
// reported as its index plus index_offset, mod 2^32, in ascending order.
// At most MAX_NEIGHBOURS results are given, status 2 marking an overflow;
// any cell sharing more than tdim vertices gives one empty result with status
// 1, a query with no neighbours one empty result with status 0, and an index
// not below cell_count one empty result with status 3. One item is worked on
// at a time; the next is taken while the final result still waits in the
// output register. Configuration writes are taken at any time and must only
// be issued while the block is idle.
module mesh_dual_graph_neighbours (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [9:0]  i_cell_index,
    input  logic [31:0] i_vertex_a,
    input  logic [31:0] i_vertex_b,
    input  logic [31:0] i_vertex_c,
    input  logic [31:0] i_vertex_d,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_neighbour_index,
    output logic        o_has_neighbour,
    output logic        o_last,
    output logic [1:0]  o_status
);
    import mdg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_QRD,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state r_state;

    // configuration
    logic [1:0]  r_tdim;
    logic [31:0] r_offset;

    // table fill level
    logic [CNT_W-1:0] r_count;

    // query context
    logic [ADDR_W-1:0] r_q;
    logic [CELL_W-1:0] r_qcell;
    logic [CNT_W-1:0]  r_j;
    logic              r_p1_vld;
    logic [ADDR_W-1:0] r_p1_idx;

    // gathered results
    logic [ADDR_W-1:0]   r_found [MAX_NEIGHBOURS];
    logic [NB_CNT_W-1:0] r_nfound;
    logic                r_ovf;
    logic                r_toomany;
    logic [NB_CNT_W-1:0] r_nres;
    logic [NB_IDX_W-1:0] r_emit;
    logic                r_has;
    logic [1:0]          r_st;

    // output register
    logic        r_out_vld;
    logic [31:0] r_out_idx;
    logic        r_out_has;
    logic        r_out_last;
    logic [1:0]  r_out_st;

    logic              in_xfer;
    logic              cfg_xfer;
    logic              out_load;
    logic              scan_done;
    logic              is_last;
    logic [1:0]        td;
    logic [2:0]        nv;
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [CELL_W-1:0] rdata;
    t_match_res        m_res;

    assign td = (r_tdim == 2'd0) ? 2'd1 : r_tdim;
    assign nv = {1'b0, td} + 3'd1;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;

    // memory port control: writes only from idle, reads for the query cell
    // and then for the scan
    assign we = in_xfer && (i_kind == KIND_LOAD) && (r_count < CNT_W'(MAX_CELLS));
    always_comb begin
        re    = 1'b0;
        raddr = r_j[ADDR_W-1:0];
        if (r_state == S_IDLE) begin
            re    = in_xfer && (i_kind == KIND_QUERY);
            raddr = ADDR_W'(i_cell_index);
        end else if (r_state == S_SCAN) begin
            re = (r_j != r_count);
        end
    end

    mdg_ram #(
        .DEPTH (MAX_CELLS),
        .WIDTH (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_vertex_d, i_vertex_c, i_vertex_b, i_vertex_a}),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    mdg_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p1_vld),
        .i_idx   (r_p1_idx),
        .i_cell  (rdata),
        .i_qcell (r_qcell),
        .i_nv    (nv),
        .o_res   (m_res)
    );

    // scan is over once every entry is issued and the pipe has drained
    assign scan_done = (r_j == r_count) && !r_p1_vld && !m_res.vld;
    assign out_load  = (r_state == S_EMIT) && (!r_out_vld || i_out_ready);
    assign is_last   = ({{(NB_CNT_W - NB_IDX_W){1'b0}}, r_emit} + NB_CNT_W'(1)) == r_nres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tdim    <= 2'd3;
            r_offset  <= '0;
            r_count   <= '0;
            r_p1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_nfound  <= '0;
            r_ovf     <= 1'b0;
            r_toomany <= 1'b0;
            r_j       <= '0;
            r_emit    <= '0;
        end else begin
            if (cfg_xfer) begin
                case (i_cfg_index)
                    CFG_TDIM:   r_tdim   <= i_cfg_data[1:0];
                    CFG_OFFSET: r_offset <= i_cfg_data;
                    default: ;
                endcase
            end

            r_p1_vld <= (r_state == S_SCAN) && (r_j != r_count);
            r_p1_idx <= r_j[ADDR_W-1:0];

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        unique case (i_kind)
                            KIND_LOAD: begin
                                if (we) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            KIND_CLEAR: begin
                                r_count <= '0;
                            end
                            KIND_QUERY: begin
                                r_q       <= ADDR_W'(i_cell_index);
                                r_nfound  <= '0;
                                r_ovf     <= 1'b0;
                                r_toomany <= 1'b0;
                                r_j       <= '0;
                                r_emit    <= '0;
                                if (32'(i_cell_index) >= 32'(r_count)) begin
                                    r_nres  <= NB_CNT_W'(1);
                                    r_has   <= 1'b0;
                                    r_st    <= ST_BAD_IDX;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_QRD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_QRD: begin
                    r_qcell <= rdata;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_j != r_count) begin
                        r_j <= r_j + CNT_W'(1);
                    end
                    if (m_res.vld && (m_res.idx != r_q)) begin
                        if (m_res.shared == {1'b0, td}) begin
                            if (r_nfound < NB_CNT_W'(MAX_NEIGHBOURS)) begin
                                r_found[r_nfound[NB_IDX_W-1:0]] <= m_res.idx;
                                r_nfound <= r_nfound + NB_CNT_W'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end else if (m_res.shared > {1'b0, td}) begin
                            r_toomany <= 1'b1;
                        end
                    end
                    if (scan_done) begin
                        r_state <= S_EMIT;
                        if (r_toomany) begin
                            r_nres <= NB_CNT_W'(1);
                            r_has  <= 1'b0;
                            r_st   <= ST_TOO_MANY;
                        end else if (r_nfound == '0) begin
                            r_nres <= NB_CNT_W'(1);
                            r_has  <= 1'b0;
                            r_st   <= ST_OK;
                        end else begin
                            r_nres <= r_nfound;
                            r_has  <= 1'b1;
                            r_st   <= r_ovf ? ST_OVERFLOW : ST_OK;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_out_idx  <= r_has ? (32'(r_found[r_emit]) + r_offset) : 32'd0;
                        r_out_has  <= r_has;
                        r_out_last <= is_last;
                        r_out_st   <= r_st;
                        r_emit     <= r_emit + NB_IDX_W'(1);
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_neighbour_index = r_out_idx;
    assign o_has_neighbour   = r_out_has;
    assign o_last            = r_out_last;
    assign o_status          = r_out_st;

    // fill level stays within the table
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CELLS))
        else $error("cell count above table depth");

    // neighbour list never grows past its capacity
    a_nfound_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfound <= NB_CNT_W'(MAX_NEIGHBOURS))
        else $error("neighbour list overrun");

    // an empty reply is always the final result of its query
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_has) |-> r_out_last)
        else $error("empty reply not marked last");

    // matcher results only arrive while a scan is running
    a_match_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_res.vld |-> (r_state == S_SCAN))
        else $error("matcher result outside scan");

endmodule
